// File: sv/skvt_pkg.sv
// shared constants, request and status codes and the cell command type
// for the sorted key/value table; depends on nothing
package skvt_pkg;

   localparam int SKVT_CAPACITY   = 64;
   localparam int SKVT_VALUE_BITS = 32;
   localparam int KEY_BITS        = 32;

   localparam logic [KEY_BITS-1:0] RESERVED_KEY = 32'hFFFF_FFFF;

   localparam logic [3:0] MODE_FIND         = 4'd0;
   localparam logic [3:0] MODE_INSERT       = 4'd1;
   localparam logic [3:0] MODE_SET          = 4'd2;
   localparam logic [3:0] MODE_ERASE_KEY    = 4'd3;
   localparam logic [3:0] MODE_ERASE_VALUE  = 4'd4;
   localparam logic [3:0] MODE_KEY_OF_VALUE = 4'd5;
   localparam logic [3:0] MODE_LAST         = 4'd6;
   localparam logic [3:0] MODE_UNUSED_KEY   = 4'd7;
   localparam logic [3:0] MODE_CLEAR        = 4'd8;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [2:0] STATUS_RESERVED  = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   typedef struct packed {
      logic capture;
      logic insert;
      logic erase;
      logic set;
   } skvt_cmd_type;

endpackage

// File: sv/skvt_cell.sv
// one table slot: key and value storage, local compare flags and the
// neighbour shift for ordered insert and erase; depends on skvt_pkg
module skvt_cell #(
   parameter int CAPACITY   = skvt_pkg::SKVT_CAPACITY,
   parameter int VALUE_BITS = skvt_pkg::SKVT_VALUE_BITS,
   parameter int INDEX      = 0
) (
   input  logic                                  clock,
   input  skvt_pkg::skvt_cmd_type                cmd,
   input  logic [$clog2(CAPACITY+1)-1:0]         count,
   input  logic [skvt_pkg::KEY_BITS-1:0]         cmp_key,
   input  logic [VALUE_BITS-1:0]                 cmp_value,
   input  logic [skvt_pkg::KEY_BITS-1:0]         wr_key,
   input  logic [VALUE_BITS-1:0]                 wr_value,
   input  logic [skvt_pkg::KEY_BITS-1:0]         left_key,
   input  logic [VALUE_BITS-1:0]                 left_value,
   input  logic                                  left_lt,
   input  logic [skvt_pkg::KEY_BITS-1:0]         right_key,
   input  logic [VALUE_BITS-1:0]                 right_value,
   input  logic                                  sel,
   input  logic                                  shift,
   output logic [skvt_pkg::KEY_BITS-1:0]         key_q,
   output logic [VALUE_BITS-1:0]                 value_q,
   output logic                                  lt_q,
   output logic                                  keq_q,
   output logic                                  veq_q,
   output logic                                  ieq_q,
   output logic                                  last_q
);
   import skvt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  lt_ff, keq_ff, veq_ff, ieq_ff, last_ff;
   logic                  occupied;

   assign occupied = count > CW'(INDEX);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.insert) begin
         // cells past the insert point take the left neighbour
         if (!left_lt) begin
            key_in   = left_key;
            value_in = left_value;
         end else if (!lt_ff) begin
            key_in   = wr_key;
            value_in = wr_value;
         end
      end else if (cmd.erase && shift) begin
         key_in   = right_key;
         value_in = right_value;
      end else if (cmd.set && sel) begin
         value_in = wr_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (cmd.capture) begin
         lt_ff   <= occupied && (key_ff < cmp_key);
         keq_ff  <= occupied && (key_ff == cmp_key);
         veq_ff  <= occupied && (value_ff == cmp_value);
         ieq_ff  <= occupied && (key_ff == KEY_BITS'(INDEX));
         last_ff <= count == CW'(INDEX + 1);
      end
   end

   assign key_q   = key_ff;
   assign value_q = value_ff;
   assign lt_q    = lt_ff;
   assign keq_q   = keq_ff;
   assign veq_q   = veq_ff;
   assign ieq_q   = ieq_ff;
   assign last_q  = last_ff;

endmodule

// File: sv/skvt_pick.sv
// isolates the lowest set flag of a row and builds the at-or-above mask
// used as erase shift; depends on nothing
module skvt_pick #(
   parameter int WIDTH = 64
) (
   input  logic [WIDTH-1:0] flags,
   output logic [WIDTH-1:0] first,
   output logic [WIDTH-1:0] at_or_above
);

   assign first       = flags & (~flags + WIDTH'(1));
   assign at_or_above = ~(first - WIDTH'(1));

endmodule

// File: sv/sorted_key_value_table.sv
// top level of the sorted key/value table: a row of skvt_cell slots, one
// skvt_pick selector and the request sequencer; depends on skvt_pkg
//
//  channel   ports                                         transfer when
//  request   start, busy, req_mode, req_key, req_value     start && !busy
//  result    rsp_strobe, rsp_status, rsp_value_out,        rsp_strobe
//            rsp_key_out, rsp_entries_used
//
//  a request runs in order: the accepting edge latches the compare flags
//  of every cell, a select cycle picks the target slot, an apply cycle
//  shifts or writes the row and registers the result
//  rsp_strobe is high for one cycle, the cycle in which start can be taken again
//  synchronous active-high reset empties the table, slot contents undefined
//  the receiver cannot stall, results are never held back
module sorted_key_value_table #(
   parameter int CAPACITY   = skvt_pkg::SKVT_CAPACITY,
   parameter int VALUE_BITS = skvt_pkg::SKVT_VALUE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_mode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [31:0] rsp_key_out,
   output logic [6:0]  rsp_entries_used
);
   import skvt_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SELECT = 3'b010,
      ST_APPLY  = 3'b100
   } state_type;

   // decision made in the select cycle
   typedef struct packed {
      logic       insert;
      logic       erase;
      logic       set;
      logic       clear;
      logic       found;
      logic [2:0] status;
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [3:0]            mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CW-1:0]         count_ff, count_in;

   logic [CAPACITY-1:0]   sel_ff, shift_ff;
   logic [CAPACITY-1:0]   lt_v, keq_v, veq_v, ieq_v, last_v;
   logic [CAPACITY-1:0]   pick_flags, pick_first, pick_above;

   logic [KEY_BITS-1:0]   cell_key [CAPACITY];
   logic [VALUE_BITS-1:0] cell_value [CAPACITY];

   logic [VALUE_BITS+31:0] req_value_wide;
   logic [VALUE_BITS-1:0]  cmp_value;
   logic                   accept;
   skvt_cmd_type           cmd;

   logic [KEY_BITS-1:0]    rd_key;
   logic [VALUE_BITS-1:0]  rd_value;
   logic [IW-1:0]          rd_index;
   logic [VALUE_BITS+31:0] rd_value_wide;
   logic [CW+6:0]          count_wide;

   logic        strobe_ff;
   logic [2:0]  status_ff;
   logic [31:0] value_out_ff, value_out_in;
   logic [31:0] key_out_ff, key_out_in;
   logic [6:0]  entries_ff;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   // value kept in its low VALUE_BITS bits, zero-filled above the port
   assign req_value_wide = {{VALUE_BITS{1'b0}}, req_value};
   assign cmp_value      = req_value_wide[VALUE_BITS-1:0];

   assign cmd.capture = accept;
   assign cmd.insert  = (state_ff == ST_APPLY) && op_ff.insert;
   assign cmd.erase   = (state_ff == ST_APPLY) && op_ff.erase;
   assign cmd.set     = (state_ff == ST_APPLY) && op_ff.set;

   // the row of slots, each wired to its left and right neighbour
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]   left_key, right_key;
      logic [VALUE_BITS-1:0] left_value, right_value;
      logic                  left_lt;

      if (i == 0) begin : g_first
         assign left_key   = '0;
         assign left_value = '0;
         assign left_lt    = 1'b1;
      end else begin : g_inner
         assign left_key   = cell_key[i-1];
         assign left_value = cell_value[i-1];
         assign left_lt    = lt_v[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign right_key   = '0;
         assign right_value = '0;
      end else begin : g_body
         assign right_key   = cell_key[i+1];
         assign right_value = cell_value[i+1];
      end

      skvt_cell #(
         .CAPACITY   (CAPACITY),
         .VALUE_BITS (VALUE_BITS),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .cmp_key     (req_key),
         .cmp_value   (cmp_value),
         .wr_key      (key_ff),
         .wr_value    (value_ff),
         .left_key    (left_key),
         .left_value  (left_value),
         .left_lt     (left_lt),
         .right_key   (right_key),
         .right_value (right_value),
         .sel         (sel_ff[i]),
         .shift       (shift_ff[i]),
         .key_q       (cell_key[i]),
         .value_q     (cell_value[i]),
         .lt_q        (lt_v[i]),
         .keq_q       (keq_v[i]),
         .veq_q       (veq_v[i]),
         .ieq_q       (ieq_v[i]),
         .last_q      (last_v[i])
      );
   end

   // flag row that the select cycle works on
   always_comb begin
      case (mode_ff)
         MODE_FIND, MODE_INSERT, MODE_SET, MODE_ERASE_KEY:
            pick_flags = keq_v;
         MODE_ERASE_VALUE, MODE_KEY_OF_VALUE:
            pick_flags = veq_v;
         MODE_LAST:
            pick_flags = last_v;
         MODE_UNUSED_KEY:
            // keys equal to their slot form a prefix; first miss is the answer
            pick_flags = ~ieq_v;
         default:
            pick_flags = '0;
      endcase
   end

   skvt_pick #(
      .WIDTH (CAPACITY)
   ) u_pick (
      .flags       (pick_flags),
      .first       (pick_first),
      .at_or_above (pick_above)
   );

   // decision for the request
   always_comb begin
      op_in        = '0;
      op_in.found  = |pick_first;
      op_in.status = STATUS_OK;
      case (mode_ff)
         MODE_FIND, MODE_ERASE_KEY, MODE_ERASE_VALUE, MODE_KEY_OF_VALUE,
         MODE_LAST, MODE_SET: begin
            if (!op_in.found) begin
               op_in.status = STATUS_NOT_FOUND;
            end else begin
               op_in.erase = (mode_ff == MODE_ERASE_KEY) ||
                             (mode_ff == MODE_ERASE_VALUE);
               op_in.set   = mode_ff == MODE_SET;
            end
         end
         MODE_INSERT: begin
            if (key_ff == RESERVED_KEY) begin
               op_in.status = STATUS_RESERVED;
            end else if (|keq_v) begin
               op_in.status = STATUS_DUPLICATE;
            end else if (count_ff == CW'(CAPACITY)) begin
               op_in.status = STATUS_FULL;
            end else begin
               op_in.insert = 1'b1;
            end
         end
         MODE_CLEAR: begin
            op_in.clear = 1'b1;
         end
         default: begin
            op_in.status = STATUS_OK;
         end
      endcase
   end

   // read-out of the selected slot
   always_comb begin
      rd_key   = '0;
      rd_value = '0;
      rd_index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (sel_ff[i]) begin
            rd_key   = rd_key | cell_key[i];
            rd_value = rd_value | cell_value[i];
            rd_index = rd_index | IW'(i);
         end
      end
   end

   assign rd_value_wide = {32'b0, rd_value};

   always_comb begin
      value_out_in = '0;
      key_out_in   = RESERVED_KEY;
      case (mode_ff) inside
         [MODE_FIND:MODE_ERASE_KEY]: begin
            key_out_in = key_ff;
         end
         MODE_ERASE_VALUE, MODE_KEY_OF_VALUE, MODE_LAST: begin
            if (op_ff.found) begin
               key_out_in = rd_key;
            end
         end
         MODE_UNUSED_KEY: begin
            // every slot holds its own index: answer is the capacity
            key_out_in = op_ff.found ? {{(32-IW){1'b0}}, rd_index} : 32'(CAPACITY);
         end
         default: begin
            key_out_in = RESERVED_KEY;
         end
      endcase
      case (mode_ff)
         MODE_FIND, MODE_ERASE_KEY, MODE_ERASE_VALUE, MODE_LAST: begin
            if (op_ff.found) begin
               value_out_in = rd_value_wide[31:0];
            end
         end
         default: begin
            value_out_in = '0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (op_ff.clear) begin
         count_in = '0;
      end else if (op_ff.insert) begin
         count_in = count_ff + CW'(1);
      end else if (op_ff.erase) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_wide = {7'b0, count_in};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= state_ff == ST_APPLY;
         if (state_ff == ST_APPLY) begin
            count_ff <= count_in;
         end
      end
   end

   // request, selection and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key;
         value_ff <= cmp_value;
      end
      if (state_ff == ST_SELECT) begin
         op_ff    <= op_in;
         sel_ff   <= pick_first;
         shift_ff <= pick_above;
      end
      if (state_ff == ST_APPLY) begin
         status_ff    <= op_ff.status;
         value_out_ff <= value_out_in;
         key_out_ff   <= key_out_in;
         entries_ff   <= count_wide[6:0];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_value_out    = value_out_ff;
   assign rsp_key_out      = key_out_ff;
   assign rsp_entries_used = entries_ff;

endmodule

// File: sv/skvt_checker.sv
// port-level checks of handshake timing and of zero values on failure for
// the sorted key/value table, bound to the top level; depends on skvt_pkg
module skvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_value_out
);
   import skvt_pkg::*;

   logic accept;

   assign accept = start && !busy;

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after a request transfer");

   a_result_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("result strobe missing three cycles after request");

   a_idle_with_result : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("busy while a result is shown");

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_value_zero_on_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_value_out == 32'd0))
      else $error("nonzero value with a failing status");

endmodule

bind sorted_key_value_table skvt_checker u_checker (.*);

// File: tb/testbench.sv
// self-checking testbench for sorted_key_value_table: directed and random
// requests, a built-in table predictor and a result checker; needs skvt_pkg
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import skvt_pkg::*;

   localparam int TABLE_DEPTH  = SKVT_CAPACITY;
   localparam int STALL_LIMIT  = 2000;  // cycles with no transfer at all
   localparam int TAIL_CYCLES  = 8;     // extra wait after the last result, for stray strobes

   // one result of the block as the checker sees it
   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [31:0] key_out;
      logic [6:0]  entries_used;
   } table_reply_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic [3:0]  req_mode  = MODE_FIND;
   logic [31:0] req_key   = '0;
   logic [31:0] req_value = '0;
   logic        busy;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value_out;
   logic [31:0] rsp_key_out;
   logic [6:0]  rsp_entries_used;

   // predictor copy of the table, kept in ascending key order
   logic [31:0] model_keys   [TABLE_DEPTH];
   logic [31:0] model_values [TABLE_DEPTH];
   int          model_count = 0;

   table_reply_type pending_replies[$];
   int              fail_count  = 0;
   bit              idling_on   = 1'b1;

   sorted_key_value_table u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_value_out    (rsp_value_out),
      .rsp_key_out      (rsp_key_out),
      .rsp_entries_used (rsp_entries_used)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // first slot whose key is not below k, model_count if none
   function automatic int first_slot_not_below(logic [31:0] k);
      int pos;
      pos = 0;
      while (pos < model_count && model_keys[pos] < k) pos++;
      return pos;
   endfunction

   // slot holding key k, model_count when absent
   function automatic int slot_of_key(logic [31:0] k);
      int pos;
      pos = first_slot_not_below(k);
      if (pos < model_count && model_keys[pos] == k) return pos;
      return model_count;
   endfunction

   // first slot in key order holding value v, model_count when absent
   function automatic int slot_of_value(logic [31:0] v);
      int pos;
      pos = 0;
      while (pos < model_count && model_values[pos] != v) pos++;
      return pos;
   endfunction

   // close the gap left by an erased slot
   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < model_count; i++) begin
         model_keys[i]   = model_keys[i + 1];
         model_values[i] = model_values[i + 1];
      end
      model_count--;
   endfunction

   // applies one request to the table copy and returns the result it causes
   function automatic table_reply_type compute_table_reply(logic [3:0] m, logic [31:0] k,
                                                           logic [31:0] v);
      table_reply_type r;
      int              pos;
      r.status    = STATUS_OK;
      r.value_out = '0;
      r.key_out   = RESERVED_KEY;
      case (m)
         MODE_FIND: begin
            r.key_out = k;
            pos = slot_of_key(k);
            if (pos < model_count) r.value_out = model_values[pos];
            else r.status = STATUS_NOT_FOUND;
         end
         MODE_INSERT: begin
            r.key_out = k;
            pos = first_slot_not_below(k);
            if (k == RESERVED_KEY) begin
               r.status = STATUS_RESERVED;
            end else if (pos < model_count && model_keys[pos] == k) begin
               r.status = STATUS_DUPLICATE;
            end else if (model_count >= TABLE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (int i = model_count; i > pos; i--) begin
                  model_keys[i]   = model_keys[i - 1];
                  model_values[i] = model_values[i - 1];
               end
               model_keys[pos]   = k;
               model_values[pos] = v;
               model_count++;
            end
         end
         MODE_SET: begin
            r.key_out = k;
            pos = slot_of_key(k);
            if (pos < model_count) model_values[pos] = v;
            else r.status = STATUS_NOT_FOUND;
         end
         MODE_ERASE_KEY: begin
            r.key_out = k;
            pos = slot_of_key(k);
            if (pos < model_count) begin
               r.value_out = model_values[pos];
               drop_slot(pos);
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
         end
         MODE_ERASE_VALUE: begin
            pos = slot_of_value(v);
            if (pos < model_count) begin
               r.value_out = model_values[pos];
               r.key_out   = model_keys[pos];
               drop_slot(pos);
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
         end
         MODE_KEY_OF_VALUE: begin
            pos = slot_of_value(v);
            if (pos < model_count) r.key_out = model_keys[pos];
            else r.status = STATUS_NOT_FOUND;
         end
         MODE_LAST: begin
            if (model_count > 0) begin
               r.value_out = model_values[model_count - 1];
               r.key_out   = model_keys[model_count - 1];
            end else begin
               r.status = STATUS_NOT_FOUND;
            end
         end
         MODE_UNUSED_KEY: begin
            pos = 0;
            while (pos < model_count && model_keys[pos] == pos) pos++;
            r.key_out = pos;
         end
         MODE_CLEAR: model_count = 0;
         default: ;  // unused modes leave the table alone
      endcase
      if (r.status != STATUS_OK) r.value_out = '0;
      r.entries_used = 7'(model_count);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // presents one request and returns at the edge that takes the transfer
   task automatic issue_request(logic [3:0] m, logic [31:0] k, logic [31:0] v);
      bit taken;
      int idle;
      if (idling_on && $urandom_range(0, 99) < 13) begin
         start <= 1'b0;
         idle = $urandom_range(1, 6);
         // only cycles in which the block could take a transfer count as idle
         while (idle > 0) begin
            @(posedge clock);
            if (!busy) idle--;
         end
      end
      start     <= 1'b1;
      req_mode  <= m;
      req_key   <= k;
      req_value <= v;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;  // start was high at this edge
      end
      pending_replies.push_back(compute_table_reply(m, k, v));
      // start stays high: the next call either drives a fresh request or idles
   endtask

   // sender holds off until every outstanding result has come back
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // every lookup on an empty table
   task automatic test_empty_table();
      issue_request(MODE_LAST, 32'h0, 32'h0);
      issue_request(MODE_UNUSED_KEY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue_request(MODE_FIND, 32'h0, 32'h0);
      issue_request(MODE_ERASE_VALUE, 32'h0, 32'h0);
      issue_request(MODE_KEY_OF_VALUE, 32'h0, 32'h0);
      issue_request(MODE_ERASE_KEY, 32'h0, 32'h0);
   endtask

   // reserved key, duplicates and ordering at the key extremes
   task automatic test_insert_rules();
      issue_request(MODE_INSERT, RESERVED_KEY, 32'h1234_5678);
      issue_request(MODE_INSERT, 32'hFFFF_FFFE, 32'h0000_0000);
      issue_request(MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      issue_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0001);
      issue_request(MODE_INSERT, 32'h0000_0001, 32'h0000_0005);
      issue_request(MODE_INSERT, 32'h0000_0003, 32'h0000_0005);
   endtask

   // the remaining modes on a small populated table
   task automatic test_lookup_and_update();
      issue_request(MODE_FIND, 32'h0000_0000, 32'h0);
      issue_request(MODE_FIND, RESERVED_KEY, 32'h0);
      issue_request(MODE_SET, 32'h0000_0002, 32'hDEAD_BEEF);   // absent key
      issue_request(MODE_SET, 32'h0000_0001, 32'hA5A5_A5A5);
      issue_request(MODE_KEY_OF_VALUE, 32'h0, 32'h0000_0005);
      issue_request(MODE_LAST, 32'h0, 32'h0);
      issue_request(MODE_UNUSED_KEY, 32'h0, 32'h0);
      issue_request(MODE_ERASE_VALUE, 32'h0, 32'h0000_0005);
      issue_request(MODE_ERASE_KEY, 32'hFFFF_FFFE, 32'h0);
      issue_request(MODE_ERASE_KEY, RESERVED_KEY, 32'h0);
      issue_request(4'd9, 32'h5555_5555, 32'hAAAA_AAAA);
      issue_request(4'd15, 32'hAAAA_AAAA, 32'h5555_5555);
      issue_request(MODE_CLEAR, 32'h0, 32'h0);
   endtask

   // fill every slot in descending key order, then push past capacity
   task automatic test_full_table();
      issue_request(MODE_CLEAR, $urandom(), $urandom());
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) issue_request(MODE_INSERT, i, $urandom());
      issue_request(MODE_UNUSED_KEY, 32'h0, 32'h0);
      issue_request(MODE_INSERT, 32'd100, 32'h1);            // full
      issue_request(MODE_INSERT, 32'd5, 32'h1);              // duplicate wins over full
      issue_request(MODE_INSERT, RESERVED_KEY, 32'h1);       // reserved wins over full
      issue_request(MODE_LAST, 32'h0, 32'h0);
      issue_request(MODE_ERASE_KEY, 32'd0, 32'h0);
      issue_request(MODE_UNUSED_KEY, 32'h0, 32'h0);
      issue_request(MODE_ERASE_VALUE, 32'h0, model_values[20]);
      issue_request(MODE_INSERT, 32'hFFFF_FFFE, 32'h7);
      issue_request(MODE_INSERT, 32'd0, 32'h8);
      issue_request(MODE_CLEAR, 32'h0, 32'h0);
   endtask

   // mostly keys and values already in the table so that lookups hit
   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return $urandom_range(0, 15);
      if (r < 60 && model_count > 0) return model_keys[$urandom_range(0, model_count - 1)];
      if (r < 64) return RESERVED_KEY;
      if (r < 68) return (r[0]) ? 32'hFFFF_FFFE : 32'h0;
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return $urandom_range(0, 7);
      if (r < 65 && model_count > 0) return model_values[$urandom_range(0, model_count - 1)];
      return $urandom();
   endfunction

   // random mix weighted towards insert so the table fills up now and then
   task automatic test_random_traffic(int n_items, bit with_idling);
      int          r;
      logic [3:0]  m;
      idling_on = with_idling;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 32)      m = MODE_INSERT;
         else if (r < 42) m = MODE_FIND;
         else if (r < 50) m = MODE_SET;
         else if (r < 58) m = MODE_ERASE_KEY;
         else if (r < 64) m = MODE_ERASE_VALUE;
         else if (r < 70) m = MODE_KEY_OF_VALUE;
         else if (r < 76) m = MODE_LAST;
         else if (r < 84) m = MODE_UNUSED_KEY;
         else if (r < 85) m = MODE_CLEAR;
         else if (r < 90) m = 4'($urandom_range(9, 15));
         else             m = MODE_FIND;
         issue_request(m, pick_key(), pick_value());
         if (i % 250 == 125) wait_for_results();
      end
      idling_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // result checker: strobed results are compared with the oldest prediction
   // ---------------------------------------------------------------
   always @(posedge clock) begin : reply_checker
      table_reply_type want;
      if (!reset && rsp_strobe) begin
         if (pending_replies.size() == 0) begin
            $error("result transfer with no request outstanding");
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_value_out !== want.value_out) begin
               $error("value_out: expected %h, got %h", want.value_out, rsp_value_out);
               fail_count++;
            end
            if (rsp_key_out !== want.key_out) begin
               $error("key_out: expected %h, got %h", want.key_out, rsp_key_out);
               fail_count++;
            end
            if (rsp_entries_used !== want.entries_used) begin
               $error("entries_used: expected %0d, got %0d", want.entries_used,
                      rsp_entries_used);
               fail_count++;
            end
         end
      end
   end

   // watchdog: ends the run after too long without any transfer
   initial begin : watchdog
      int quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("testbench failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_insert_rules();
      test_lookup_and_update();
      test_full_table();
      test_random_traffic(1100, 1'b1);
      test_random_traffic(650, 1'b0);   // back-to-back stretch with no idling

      // let the last results drain, then a few more cycles for stray strobes
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) $display("testbench passed");
      else $display("testbench failed");
      $finish;
   end

endmodule

// File: files.f
sv/skvt_pkg.sv
sv/skvt_cell.sv
sv/skvt_pick.sv
sv/sorted_key_value_table.sv
sv/skvt_checker.sv
tb/testbench.sv
